// File: rtl/btkem_pkg.sv
// Shared types and constants for the button-to-key event mapper.
// Used by the divider, the top level and the port checker; depends on nothing.
`default_nettype none

package btkem_pkg;

    // Binding table size and register widths.
    localparam int MAX_BINDINGS_DEFAULT = 32;
    localparam int CFG_W                = 6;
    localparam logic [CFG_W-1:0] ENTRIES_RESET = 6'd1;

    // Microsecond to millisecond conversion, one 16-bit digit at a time. Each
    // quotient digit comes from a reciprocal multiplication that is exact for
    // any partial dividend below 2^26.
    localparam int DIVIDEND_W  = 64;
    localparam int QUOT_W      = 32;
    localparam int DIVISOR     = 1000;
    localparam int REM_W       = 10;
    localparam int DIGIT_W     = 16;
    localparam int NUM_DIGITS  = DIVIDEND_W / DIGIT_W;
    localparam int PART_W      = REM_W + DIGIT_W;
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 27'd68719477;
    localparam int PROD_W      = PART_W + RECIP_W;
    localparam int STEP_W      = 3;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * NUM_DIGITS - 1);

    // Request type codes.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DECIDE,
        ST_READ,
        ST_EVAL,
        ST_FLUSH
    } state_t;

    // One binding table entry.
    typedef struct packed {
        logic [31:0] mask;
        logic [15:0] key;
        logic [15:0] scan;
        logic        ext;
    } bind_t;

    // One key event as it leaves the block.
    typedef struct packed {
        logic [15:0] key;
        logic [15:0] scan;
        logic        ext;
        logic        down;
        logic [31:0] ms;
        logic        last;
    } event_t;

    // Status of the divider towards the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage : btkem_pkg

`default_nettype wire

// File: rtl/btkem_div1000.sv
// Divider that turns a 64-bit microsecond count into milliseconds, one 16-bit
// quotient digit at a time by reciprocal multiplication. Depends on btkem_pkg.
`default_nettype none

module btkem_div1000
    import btkem_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    output div_stat_t                  stat,
    output logic [QUOT_W-1:0]          quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] num_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [QUOT_W-1:0]     quo_reg;
    logic [PROD_W-1:0]     prod_reg;

    logic [PART_W-1:0]     part;
    logic [DIGIT_W-1:0]    digit;
    logic [PART_W-1:0]     digit_x_div;
    logic [PART_W-1:0]     part_rem;

    // The partial dividend is the running remainder followed by the next digit.
    // The quotient digit comes from the registered reciprocal product, and the
    // new remainder is what is left after taking the digit times 1000 away.
    always_comb
    begin
        part        = {rem_reg, num_reg[DIVIDEND_W-1 -: DIGIT_W]};
        digit       = prod_reg[RECIP_SHIFT +: DIGIT_W];
        digit_x_div = PART_W'(digit) * PART_W'(DIVISOR);
        part_rem    = part - digit_x_div;
    end

    // Step counter and completion flag; bit 0 of the count selects the phase.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath: multiply in the first phase, take the digit and remainder in the
    // second. Only the two low quotient digits are kept, the upper ones shift out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!cnt_reg[0])
            begin
                prod_reg <= PROD_W'(part) * PROD_W'(DIV_RECIP);
            end
            else
            begin
                num_reg <= {num_reg[DIVIDEND_W-DIGIT_W-1:0], DIGIT_W'(0)};
                rem_reg <= part_rem[REM_W-1:0];
                quo_reg <= {quo_reg[QUOT_W-DIGIT_W-1:0], digit};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule : btkem_div1000

`default_nettype wire

// File: rtl/button_to_key_event_mapper_unit.sv
// Top level of the button-to-key event mapper: binding table, sequencer and
// event output register. Depends on btkem_pkg and btkem_div1000.
//
// Usage: requests arrive on the in_valid/in_ready channel. A load request
// (req_type high) writes one binding table entry in the cycle it is accepted
// and produces no event; in_ready stays high, so loads run one per cycle.
// A pad sample first converts time_us to milliseconds in the divider, four
// digits, each a multiply and then a digit phase, passes a decision state, then
// scans the first entries_in_use table entries (at most MAX_BINDINGS), each
// read and then evaluated: once, twice on a generation change while buttons
// are held, or not at all for a disconnected or intercepted pad with none held.
// It ends in a flush state, and in_ready stays low until it is back in idle.
// Events leave on out_valid/out_ready through an output register; each event
// is held back one step in a pending register so that the last event of a
// sample can carry last_event. When the receiver stalls, the scan stops at
// the next matching entry until the output register frees up. The
// configuration register entries_in_use is written through cfg_write/cfg_data;
// the user must write it only while idle, which the block does not enforce.
// Reset clears the held buttons, the generation tracking and both output
// stages and sets entries_in_use to one; the binding table is not cleared.
`default_nettype none

module button_to_key_event_mapper_unit
    import btkem_pkg::*;
#(
    parameter int MAX_BINDINGS = MAX_BINDINGS_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // Configuration port
    input  wire logic             cfg_write,
    input  wire logic [CFG_W-1:0] cfg_data,
    // Request channel
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             req_type,
    input  wire logic [31:0]      buttons,
    input  wire logic             pad_connected,
    input  wire logic             intercepted,
    input  wire logic [31:0]      pad_generation,
    input  wire logic [63:0]      time_us,
    input  wire logic [4:0]       entry_index,
    input  wire logic [31:0]      entry_mask,
    input  wire logic [15:0]      entry_key,
    input  wire logic [15:0]      entry_scan,
    input  wire logic             entry_extended,
    // Event channel
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [15:0]           key_code,
    output logic [15:0]           scan_out,
    output logic                  extended_out,
    output logic                  key_down,
    output logic [31:0]           time_ms,
    output logic                  last_event
);

    localparam int AW = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1;
    localparam logic [CFG_W-1:0] MAX_CNT = CFG_W'(MAX_BINDINGS);

    // Control state
    state_t           state_reg, state_next;
    logic [CFG_W-1:0] idx_reg, idx_next;
    logic             second_reg, second_next;
    logic [31:0]      held_reg, held_next;
    logic [31:0]      seen_gen_reg, seen_gen_next;
    logic             gen_known_reg, gen_known_next;
    logic [CFG_W-1:0] entries_reg;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;

    // Payload state
    logic [31:0]      buttons_reg;
    logic             conn_reg;
    logic             icpt_reg;
    logic [31:0]      gen_reg;
    logic [31:0]      next_btn_reg, next_btn_next;
    event_t           pend_reg, pend_next;
    event_t           out_reg, out_next;

    // Binding table
    bind_t            bind_mem [MAX_BINDINGS];
    bind_t            rd_reg;
    logic             rd_en;
    logic             wr_en;

    // Divider
    logic             div_start;
    div_stat_t        div_stat;
    logic [QUOT_W-1:0] div_quot;

    logic             accept;
    logic             out_free;
    logic [CFG_W-1:0] lim;
    logic             hit;
    event_t           new_ev;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign lim      = (entries_reg > MAX_CNT) ? MAX_CNT : entries_reg;
    assign wr_en    = accept && (req_type == REQ_LOAD)
                      && ({1'b0, entry_index} < MAX_CNT);

    btkem_div1000 u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (time_us),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Table write on a load transaction, registered read for the scan.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bind_mem[entry_index[AW-1:0]] <= '{mask: entry_mask, key: entry_key,
                                               scan: entry_scan, ext: entry_extended};
        end
        if (rd_en)
        begin
            rd_reg <= bind_mem[idx_reg[AW-1:0]];
        end
    end

    // Event candidate from the entry just read.
    always_comb
    begin
        hit         = |((held_reg ^ next_btn_reg) & rd_reg.mask);
        new_ev.key  = rd_reg.key;
        new_ev.scan = rd_reg.scan;
        new_ev.ext  = rd_reg.ext;
        new_ev.down = |(next_btn_reg & rd_reg.mask);
        new_ev.ms   = div_quot;
        new_ev.last = 1'b0;
    end

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        second_next     = second_reg;
        held_next       = held_reg;
        seen_gen_next   = seen_gen_reg;
        gen_known_next  = gen_known_reg;
        next_btn_next   = next_btn_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        in_ready        = 1'b0;
        div_start       = 1'b0;
        rd_en           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (req_type == REQ_SAMPLE))
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                idx_next    = '0;
                second_next = 1'b0;
                if (!conn_reg || icpt_reg)
                begin
                    // Neutralise: release whatever is held, if anything.
                    next_btn_next = '0;
                    state_next    = (held_reg != '0) ? ST_READ : ST_FLUSH;
                end
                else
                begin
                    seen_gen_next  = gen_reg;
                    gen_known_next = 1'b1;
                    if (gen_known_reg && (gen_reg != seen_gen_reg) && (held_reg != '0))
                    begin
                        // New generation: release pass first, then the sample.
                        next_btn_next = '0;
                        second_next   = 1'b1;
                    end
                    else
                    begin
                        next_btn_next = buttons_reg;
                    end
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                if (idx_reg >= lim)
                begin
                    // End of a pass: the compared buttons become the held ones.
                    held_next = next_btn_reg;
                    idx_next  = '0;
                    if (second_reg)
                    begin
                        second_next   = 1'b0;
                        next_btn_next = buttons_reg;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                if (!hit)
                begin
                    idx_next   = idx_reg + CFG_W'(1);
                    state_next = ST_READ;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                    end
                    pend_next       = new_ev;
                    pend_valid_next = 1'b1;
                    idx_next        = idx_reg + CFG_W'(1);
                    state_next      = ST_READ;
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            second_reg     <= 1'b0;
            held_reg       <= '0;
            seen_gen_reg   <= '0;
            gen_known_reg  <= 1'b0;
            entries_reg    <= ENTRIES_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            second_reg     <= second_next;
            held_reg       <= held_next;
            seen_gen_reg   <= seen_gen_next;
            gen_known_reg  <= gen_known_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write)
            begin
                entries_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept && (req_type == REQ_SAMPLE))
        begin
            buttons_reg <= buttons;
            conn_reg    <= pad_connected;
            icpt_reg    <= intercepted;
            gen_reg     <= pad_generation;
        end
        next_btn_reg <= next_btn_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign key_code     = out_reg.key;
    assign scan_out     = out_reg.scan;
    assign extended_out = out_reg.ext;
    assign key_down     = out_reg.down;
    assign time_ms      = out_reg.ms;
    assign last_event   = out_reg.last;

endmodule : button_to_key_event_mapper_unit

`default_nettype wire

// File: rtl/btkem_checker.sv
// Port-level checker for the button-to-key event mapper and its bind.
// Depends on btkem_pkg and on the top level's port names.
`default_nettype none

module btkem_checker
    import btkem_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        req_type,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] key_code,
    input wire logic [15:0] scan_out,
    input wire logic        extended_out,
    input wire logic        key_down,
    input wire logic [31:0] time_ms,
    input wire logic        last_event
);

    // A stalled event transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_code)
            && $stable(scan_out) && $stable(extended_out) && $stable(key_down)
            && $stable(time_ms) && $stable(last_event))
        else $error("event payload changed while stalled");

    // A sample transaction occupies the block for the following cycles.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == REQ_SAMPLE) |=> !in_ready)
        else $error("block ready right after a sample");

    // A load transaction leaves the block ready for the next request.
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == REQ_LOAD) |=> in_ready)
        else $error("block not ready after a load");

    // When idle, any event still waiting is the final one of its sample.
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last_event)
        else $error("idle with a non-final event waiting");

endmodule : btkem_checker

bind button_to_key_event_mapper_unit btkem_checker u_btkem_checker (.*);

`default_nettype wire
